>>> rtl/lfcr_pkg.sv
// ----------------------------------------------------------------------------
// lfcr_pkg
// Types, constants and the CRC-16 byte update for the length-framed CRC
// receiver.
// ----------------------------------------------------------------------------
package lfcr_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  LIMIT_RESET  = 8'd13;
  localparam logic [7:0]  FILL_COMMAND = 8'd6;
  localparam logic [7:0]  ACK_BYTE     = 8'd1;
  localparam logic [7:0]  NAK_BYTE     = 8'd0;
  localparam logic [7:0]  LEN_RESET    = 8'd0;
  localparam logic [7:0]  LEN_FILL     = 8'd1;
  localparam logic [2:0]  LAST_REPLY   = 3'd4;

  typedef enum logic [2:0] {
    ST_CRC_GOOD = 3'd0,
    ST_CRC_BAD  = 3'd1,
    ST_RESET    = 3'd2,
    ST_FILL     = 3'd3,
    ST_ABORT    = 3'd4
  } frame_status_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    command;
    logic [15:0]   crc_calc;
    logic [15:0]   crc_rx;
  } result_desc_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/length_framed_crc_receiver_unit.sv
// ----------------------------------------------------------------------------
// length_framed_crc_receiver_unit
// Frames received bytes by a leading length, checks the CRC-16 of each frame
// and reports the outcome, with an acknowledge or a negative acknowledge and
// both CRC values to send back.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | in_rx_byte
//  out     | out_valid/out_stall| out_send_valid, out_reply_byte,
//          |                    | out_frame_command, out_frame_status,
//          |                    | out_last_of_run
//  cfg     | cfg_valid/cfg_ready| cfg_zero_run_limit
//
// A byte is framed and its CRC updated in the cycle it is accepted; one byte
// can be accepted every cycle while in_stall is low. A finished frame gives
// one result item, or five for a CRC mismatch, delivered one per cycle while
// out_stall is low from a result register. A second finished frame waits in a
// holding register; in_stall is raised only while that register is full.
// Reset is synchronous and clears all framing state, the zero-run limit returns to 13.
module length_framed_crc_receiver_unit
  import lfcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_send_valid,
  output logic [7:0] out_reply_byte,
  output logic [7:0] out_frame_command,
  output logic [2:0] out_frame_status,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_zero_run_limit
);

  logic [7:0]   limit_r;
  logic         in_frame_r, in_frame_nxt;
  logic [7:0]   len_r, len_nxt;
  logic [7:0]   pos_r, pos_nxt;
  logic [15:0]  crc_r, crc_nxt;
  logic [7:0]   zrun_r, zrun_nxt;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [7:0]   prev_r, prev_nxt;

  logic         res_vld;
  result_desc_t res;

  result_desc_t out_desc_r, out_desc_nxt;
  logic         out_busy_r, out_busy_nxt;
  logic [2:0]   idx_r, idx_nxt;
  result_desc_t pend_desc_r, pend_desc_nxt;
  logic         pend_vld_r, pend_vld_nxt;

  logic         accept;
  logic         taken;
  logic         last_take;
  logic         out_free;
  logic [15:0]  rx_crc;
  logic [15:0]  crc_upd;
  logic [7:0]   zrun_cnt;

  assign cfg_ready = 1'b1;
  assign in_stall  = pend_vld_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_busy_r;
  assign taken     = out_valid && !out_stall;
  assign last_take = taken && out_last_of_run;
  assign out_free  = !out_busy_r || last_take;

  assign crc_upd = crc_update(in_frame_r ? crc_r : 16'h0000, in_rx_byte);
  assign rx_crc  = {prev_r, in_rx_byte};

  // Framing of one accepted byte.
  always_comb begin
    in_frame_nxt = in_frame_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    zrun_nxt     = zrun_r;
    cmd_nxt      = cmd_r;
    prev_nxt     = prev_r;
    zrun_cnt     = zrun_r;
    res_vld      = 1'b0;
    res.status   = ST_RESET;
    res.command  = 8'h00;
    res.crc_calc = 16'h0000;
    res.crc_rx   = 16'h0000;
    if (accept) begin
      prev_nxt = in_rx_byte;
      if (!in_frame_r) begin
        if (in_rx_byte == LEN_RESET) begin
          zrun_nxt   = 8'h00;
          cmd_nxt    = 8'h00;
          res_vld    = 1'b1;
          res.status = ST_RESET;
        end else if (in_rx_byte == LEN_FILL) begin
          zrun_nxt    = 8'h00;
          cmd_nxt     = FILL_COMMAND;
          res_vld     = 1'b1;
          res.status  = ST_FILL;
          res.command = FILL_COMMAND;
        end else begin
          crc_nxt      = crc_upd;
          len_nxt      = in_rx_byte;
          pos_nxt      = 8'd1;
          in_frame_nxt = 1'b1;
        end
      end else begin
        if (({1'b0, pos_r} + 9'd3) <= {1'b0, len_r}) begin
          crc_nxt = crc_upd;
        end
        if (pos_r == 8'd1) begin
          cmd_nxt = in_rx_byte;
        end
        if (in_rx_byte == 8'h00) begin
          zrun_cnt = (zrun_r != 8'hff) ? zrun_r + 8'd1 : zrun_r;
        end else begin
          zrun_cnt = 8'h00;
        end
        zrun_nxt = zrun_cnt;
        if (limit_r != 8'h00 && zrun_cnt >= limit_r) begin
          zrun_nxt     = 8'h00;
          cmd_nxt      = 8'h00;
          in_frame_nxt = 1'b0;
          res_vld      = 1'b1;
          res.status   = ST_ABORT;
        end else if (({1'b0, pos_r} + 9'd1) < {1'b0, len_r}) begin
          pos_nxt = pos_r + 8'd1;
        end else begin
          in_frame_nxt = 1'b0;
          res_vld      = 1'b1;
          res.status   = (rx_crc == crc_nxt) ? ST_CRC_GOOD : ST_CRC_BAD;
          res.command  = cmd_nxt;
          res.crc_calc = crc_nxt;
          res.crc_rx   = rx_crc;
        end
      end
    end
  end

  // Result register and holding register.
  always_comb begin
    out_desc_nxt  = out_desc_r;
    out_busy_nxt  = out_busy_r;
    idx_nxt       = idx_r;
    pend_desc_nxt = pend_desc_r;
    pend_vld_nxt  = pend_vld_r;
    if (taken && !out_last_of_run) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (last_take) begin
      out_busy_nxt = 1'b0;
    end
    if (res_vld) begin
      if (out_free) begin
        out_desc_nxt = res;
        out_busy_nxt = 1'b1;
        idx_nxt      = 3'd0;
      end else begin
        pend_desc_nxt = res;
        pend_vld_nxt  = 1'b1;
      end
    end else if (last_take && pend_vld_r) begin
      out_desc_nxt = pend_desc_r;
      out_busy_nxt = 1'b1;
      idx_nxt      = 3'd0;
      pend_vld_nxt = 1'b0;
    end
  end

  // Result item fields.
  always_comb begin
    out_frame_command = out_desc_r.command;
    out_frame_status  = out_desc_r.status;
    out_send_valid    = 1'b0;
    out_reply_byte    = 8'h00;
    out_last_of_run   = 1'b1;
    unique case (out_desc_r.status)
      ST_CRC_GOOD: begin
        out_send_valid = 1'b1;
        out_reply_byte = ACK_BYTE;
      end
      ST_CRC_BAD: begin
        out_send_valid  = 1'b1;
        out_last_of_run = (idx_r == LAST_REPLY);
        unique case (idx_r)
          3'd0:    out_reply_byte = NAK_BYTE;
          3'd1:    out_reply_byte = out_desc_r.crc_calc[15:8];
          3'd2:    out_reply_byte = out_desc_r.crc_calc[7:0];
          3'd3:    out_reply_byte = out_desc_r.crc_rx[15:8];
          default: out_reply_byte = out_desc_r.crc_rx[7:0];
        endcase
      end
      default: begin
        out_send_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_RESET;
      in_frame_r <= 1'b0;
      len_r      <= 8'h00;
      pos_r      <= 8'h00;
      crc_r      <= 16'h0000;
      zrun_r     <= 8'h00;
      cmd_r      <= 8'h00;
      prev_r     <= 8'h00;
      out_busy_r <= 1'b0;
      idx_r      <= 3'd0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_zero_run_limit;
      end
      in_frame_r <= in_frame_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      zrun_r     <= zrun_nxt;
      cmd_r      <= cmd_nxt;
      prev_r     <= prev_nxt;
      out_busy_r <= out_busy_nxt;
      idx_r      <= idx_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_desc_r  <= out_desc_nxt;
    pend_desc_r <= pend_desc_nxt;
  end

endmodule

>>> tb/length_framed_crc_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// length_framed_crc_receiver_unit_tb
// Self-checking testbench for the length-framed CRC-16 receiver. Received
// bytes are driven one item at a time and a byte-level copy of the framing,
// zero-run and CRC logic works out the result items that each byte causes.
// A separate process checks every result item against the oldest pending
// one. Reset and fill frames, good and bad CRCs, zero-run aborts at several
// limits, back-pressure and three random phases with varied idling are run.
// ----------------------------------------------------------------------------
module length_framed_crc_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfcr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic          send_valid;
    logic [7:0]    reply_byte;
    logic [7:0]    frame_command;
    frame_status_t frame_status;
    logic          last_of_run;
  } reply_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_send_valid;
  logic [7:0] out_reply_byte;
  logic [7:0] out_frame_command;
  logic [2:0] out_frame_status;
  logic       out_last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_zero_run_limit = 8'h00;

  length_framed_crc_receiver_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_valid    (out_send_valid),
    .out_reply_byte    (out_reply_byte),
    .out_frame_command (out_frame_command),
    .out_frame_status  (out_frame_status),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_zero_run_limit(cfg_zero_run_limit)
  );

  reply_item_t pending_replies[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          hold_request = 0;

  logic        rx_in_frame = 1'b0;
  logic [7:0]  rx_length = 8'h00;
  logic [7:0]  rx_position = 8'h00;
  logic [15:0] rx_crc_acc = 16'h0000;
  logic [7:0]  rx_zero_run = 8'h00;
  logic [7:0]  rx_command = 8'h00;
  logic [7:0]  rx_previous = 8'h00;
  logic [7:0]  rx_zero_limit = LIMIT_RESET;

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic logic [15:0] xmodem_next(input logic [15:0] acc, input octet_t b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    repeat (8) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void queue_reply(input logic sv, input octet_t rb, input octet_t cmd,
                                      input frame_status_t st, input logic last);
    reply_item_t r;
    r.send_valid    = sv;
    r.reply_byte    = rb;
    r.frame_command = cmd;
    r.frame_status  = st;
    r.last_of_run   = last;
    pending_replies.push_back(r);
  endfunction

  function automatic void frame_rx_byte(input octet_t b);
    logic [15:0] got_crc;
    if (!rx_in_frame) begin
      rx_previous = b;
      if (b == LEN_RESET) begin
        rx_zero_run = 8'h00;
        rx_command  = 8'h00;
        queue_reply(1'b0, 8'h00, 8'h00, ST_RESET, 1'b1);
      end else if (b == LEN_FILL) begin
        rx_zero_run = 8'h00;
        rx_command  = FILL_COMMAND;
        queue_reply(1'b0, 8'h00, FILL_COMMAND, ST_FILL, 1'b1);
      end else begin
        rx_crc_acc  = xmodem_next(16'h0000, b);
        rx_length   = b;
        rx_position = 8'd1;
        rx_in_frame = 1'b1;
      end
    end else begin
      if (int'(rx_position) + 3 <= int'(rx_length)) begin
        rx_crc_acc = xmodem_next(rx_crc_acc, b);
      end
      if (rx_position == 8'd1) begin
        rx_command = b;
      end
      if (b == 8'h00) begin
        if (rx_zero_run != 8'hff) begin
          rx_zero_run = rx_zero_run + 8'd1;
        end
      end else begin
        rx_zero_run = 8'h00;
      end
      if (rx_zero_limit != 8'h00 && rx_zero_run >= rx_zero_limit) begin
        rx_zero_run = 8'h00;
        rx_command  = 8'h00;
        rx_in_frame = 1'b0;
        rx_previous = b;
        queue_reply(1'b0, 8'h00, 8'h00, ST_ABORT, 1'b1);
      end else if (int'(rx_position) + 1 < int'(rx_length)) begin
        rx_position = rx_position + 8'd1;
        rx_previous = b;
      end else begin
        rx_in_frame = 1'b0;
        got_crc     = {rx_previous, b};
        rx_previous = b;
        if (got_crc == rx_crc_acc) begin
          queue_reply(1'b1, ACK_BYTE, rx_command, ST_CRC_GOOD, 1'b1);
        end else begin
          queue_reply(1'b1, NAK_BYTE, rx_command, ST_CRC_BAD, 1'b0);
          queue_reply(1'b1, rx_crc_acc[15:8], rx_command, ST_CRC_BAD, 1'b0);
          queue_reply(1'b1, rx_crc_acc[7:0], rx_command, ST_CRC_BAD, 1'b0);
          queue_reply(1'b1, got_crc[15:8], rx_command, ST_CRC_BAD, 1'b0);
          queue_reply(1'b1, got_crc[7:0], rx_command, ST_CRC_BAD, 1'b1);
        end
      end
    end
  endfunction

  task automatic check_reply();
    reply_item_t want;
    if (pending_replies.size() == 0) begin
      $error("unexpected result item: reply_byte %0d status %0d", out_reply_byte,
             out_frame_status);
      fail_count++;
    end else begin
      want = pending_replies.pop_front();
      if (out_send_valid !== want.send_valid) begin
        $error("send_valid: expected %0d, actual %0d", want.send_valid, out_send_valid);
        fail_count++;
      end
      if (out_reply_byte !== want.reply_byte) begin
        $error("reply_byte: expected %0d, actual %0d", want.reply_byte, out_reply_byte);
        fail_count++;
      end
      if (out_frame_command !== want.frame_command) begin
        $error("frame_command: expected %0d, actual %0d", want.frame_command,
               out_frame_command);
        fail_count++;
      end
      if (out_frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, actual %0d", want.frame_status,
               out_frame_status);
        fail_count++;
      end
      if (out_last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run, out_last_of_run);
        fail_count++;
      end
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_reply();
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[length_framed_crc_receiver_unit] ERROR");
    $finish;
  end

  task automatic send_byte(input octet_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    frame_rx_byte(b);
  endtask

  // Sends the first cut bytes of a frame of length len; a good frame of three or
  // more bytes carries its own CRC in the last two bytes.
  task automatic send_frame(input int len, input bit good, input int zero_pct, input int cut);
    octet_t body[$];
    logic [15:0] acc;
    int i;
    body.push_back(octet_t'(len));
    for (i = 1; i < len; i++) begin
      body.push_back(($urandom_range(99) < zero_pct) ? 8'h00 : octet_t'($urandom_range(255)));
    end
    if (good && len >= 3) begin
      acc = 16'h0000;
      for (i = 0; i <= len - 3; i++) begin
        acc = xmodem_next(acc, body[i]);
      end
      body[len-2] = acc[15:8];
      body[len-1] = acc[7:0];
    end
    for (i = 0; i < cut; i++) begin
      send_byte(body[i]);
    end
  endtask

  task automatic settle();
    while (rx_in_frame) begin
      send_byte(8'h5a);
    end
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_zero_run_limit(input octet_t value);
    cfg_valid          <= 1'b1;
    cfg_zero_run_limit <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid     <= 1'b0;
    rx_zero_limit  = value;
  endtask

  task automatic test_reset_and_fill_frames();
    send_byte(LEN_RESET);
    send_byte(LEN_FILL);
    send_byte(LEN_FILL);
    send_byte(LEN_RESET);
    settle();
  endtask

  task automatic test_crc_check();
    send_frame(5, 1'b1, 0, 5);
    send_frame(3, 1'b1, 0, 3);
    send_frame(4, 1'b0, 0, 4);
    send_frame(2, 1'b0, 0, 2);
    send_byte(8'd6);
    send_byte(8'hff);
    settle();
  endtask

  task automatic test_zero_run_abort();
    write_zero_run_limit(8'd1);
    send_byte(8'd6);
    send_byte(8'd9);
    send_byte(8'd0);
    settle();
    write_zero_run_limit(8'd2);
    send_byte(8'd4);
    send_byte(8'd7);
    send_byte(8'd0);
    send_byte(8'd0);
    settle();
    write_zero_run_limit(8'd3);
    send_byte(8'd3);
    send_byte(8'd5);
    send_byte(8'd0);
    send_byte(8'd4);
    send_byte(8'd0);
    send_byte(8'd0);
    settle();
  endtask

  // The zero run of a finished frame carries into the next one, and the abort
  // on the last byte of a frame wins over its CRC check.
  task automatic test_zero_run_across_frames();
    write_zero_run_limit(8'd20);
    send_byte(8'd12);
    repeat (11) send_byte(8'h00);
    send_byte(8'd10);
    repeat (9) send_byte(8'h00);
    settle();
  endtask

  task automatic test_back_pressure();
    int n;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_request      = HOLD_CYCLES;
    for (n = 0; n < 8; n++) begin
      send_frame(4, 1'b0, 0, 4);
    end
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    send_frame(6, 1'b1, 20, 6);
    send_frame(5, 1'b0, 20, 5);
    settle();
  endtask

  task automatic run_random_phase(input int snd_pct, input int rcv_pct, input octet_t limit,
                                  input int byte_budget);
    int sent;
    int pick;
    int len;
    int cut;
    int zero_pct;
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    write_zero_run_limit(limit);
    sent = 0;
    while (sent < byte_budget) begin
      pick     = $urandom_range(99);
      zero_pct = ($urandom_range(3) == 0) ? 60 : 10;
      pick     = $urandom_range(99);
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(10, 2);
      end else if ($urandom_range(99) < 90) begin
        len = $urandom_range(40, 11);
      end else begin
        len = $urandom_range(80, 41);
      end
      if (pick < 72) begin
        send_frame(len, 1'($urandom_range(1)), zero_pct, len);
        sent += len;
      end else if (pick < 80) begin
        send_byte(octet_t'($urandom_range(1)));
        sent++;
      end else if (pick < 90) begin
        cut = $urandom_range(5, 1);
        repeat (cut) send_byte(octet_t'($urandom_range(31)));
        sent += cut;
      end else begin
        cut = $urandom_range(len - 1, 1);
        send_frame(len, 1'b1, zero_pct, cut);
        sent += cut;
      end
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct   = 23;
    receiver_idle_pct = 60;
    test_reset_and_fill_frames();
    test_crc_check();
    test_zero_run_abort();
    test_zero_run_across_frames();
    test_back_pressure();
    run_random_phase(23, 60, 8'd4, 40);
    run_random_phase(60, 23, LIMIT_RESET, 40);
    run_random_phase(0, 0, octet_t'($urandom_range(20, 1)), 40);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("[length_framed_crc_receiver_unit] OK");
    end else begin
      $display("[length_framed_crc_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
